@@ rtl/hed_pkg.sv @@
// ----------------------------------------------------------------------------
// hed_pkg: shared types, constants and helpers for the entity decoder
// entity name table, character codes, sequencer states and the
// whitespace normaliser step function
// ----------------------------------------------------------------------------
package hed_pkg;

	// entity lookahead window and derived sizes
	localparam int ENTITY_WINDOW = 12;
	localparam int CNT_W         = $clog2(ENTITY_WINDOW + 1);
	localparam int BUF_DEPTH     = 2 ** CNT_W;
	localparam int PTR_W         = $clog2(BUF_DEPTH);
	localparam int NUM_ENT       = 28;
	localparam int NAME_MAX      = 6;

	// operation codes
	localparam logic [1:0] OP_TEXT   = 2'd0;
	localparam logic [1:0] OP_END    = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// character codes
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_QM   = 8'h3F;
	localparam logic [8:0] NBSP_CODE = 9'd160;
	localparam logic [8:0] SAT_CODE  = 9'd256;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROC,
		ST_DRAIN,
		ST_FINSP,
		ST_FLUSH
	} state_t;

	// normaliser step result
	typedef struct packed {
		logic [1:0] n_emit;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       pend;
		logic       seen;
		logic       lwn;
	} pc_t;

	// entity names, right-aligned in a six-character field
	localparam logic [8*NAME_MAX-1:0] ENT_NAME [NUM_ENT] = '{
		48'("amp"), 48'("lt"), 48'("gt"), 48'("quot"), 48'("apos"),
		48'("nbsp"), 48'("copy"), 48'("reg"), 48'("deg"),
		48'("plusmn"), 48'("laquo"), 48'("raquo"), 48'("mdash"),
		48'("ndash"), 48'("hellip"), 48'("ldquo"), 48'("rdquo"),
		48'("lsquo"), 48'("rsquo"), 48'("trade"), 48'("times"),
		48'("divide"), 48'("middot"), 48'("bull"), 48'("euro"),
		48'("pound"), 48'("yen"), 48'("sect")
	};

	localparam logic [2:0] ENT_LEN [NUM_ENT] = '{
		3'd3, 3'd2, 3'd2, 3'd4, 3'd4,
		3'd4, 3'd4, 3'd3, 3'd3,
		3'd6, 3'd5, 3'd5, 3'd5,
		3'd5, 3'd6, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd5, 3'd5,
		3'd6, 3'd6, 3'd4, 3'd4,
		3'd5, 3'd3, 3'd4
	};

	localparam logic [7:0] ENT_CH [NUM_ENT] = '{
		8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27,
		8'h20, 8'hA9, 8'hAE, 8'hB0,
		8'hB1, 8'hAB, 8'hBB, 8'h2D,
		8'h2D, 8'h2E, 8'h27, 8'h27,
		8'h27, 8'h27, 8'h2A, 8'h78,
		8'h2F, 8'h2E, 8'h2A, 8'h45,
		8'hA3, 8'hA5, 8'hA7
	};

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	// character j of entity name k, zero past the end of the name
	function automatic logic [7:0] ent_chr(input int k, input logic [CNT_W-1:0] j);
		logic [2:0] len;
		logic [2:0] idx;
		logic [7:0] r;
		len = ENT_LEN[k];
		r   = CH_NUL;
		if (j < CNT_W'(len)) begin
			idx = len - 3'd1 - j[2:0];
			r   = ENT_NAME[k][{idx, 3'b000} +: 8];
		end
		return r;
	endfunction

	// one character through the whitespace normaliser
	function automatic pc_t put_char(input logic [7:0] ch_in, input logic [15:0] cap,
			input logic [15:0] oc, input logic pend, input logic seen, input logic lwn);
		pc_t         r;
		logic [7:0]  ch;
		logic [16:0] oc1;
		logic [16:0] oc2;
		logic [16:0] capx;
		ch   = (ch_in == CH_CR || ch_in == CH_TAB || ch_in == CH_FF) ? CH_SP : ch_in;
		capx = {1'b0, cap};
		oc1  = {1'b0, oc} + 17'd1;
		oc2  = {1'b0, oc} + 17'd2;
		r.n_emit = 2'd0;
		r.b0     = ch;
		r.b1     = ch;
		r.pend   = pend;
		r.seen   = seen;
		r.lwn    = lwn;
		if (cap != 16'd0) begin
			if (ch == CH_NL) begin
				r.pend = 1'b0;
				r.seen = 1'b1;
				if (!(oc != 16'd0 && lwn) && oc1 < capx) begin
					r.n_emit = 2'd1;
					r.lwn    = 1'b1;
				end
			end else if (ch == CH_SP) begin
				if (!((oc == 16'd0 && !pend) || seen || (!pend && lwn))) begin
					r.seen = 1'b1;
					if (!pend && oc1 < capx) r.pend = 1'b1;
				end
			end else begin
				r.seen = 1'b0;
				if (pend) begin
					if (oc2 < capx) begin
						r.n_emit = 2'd2;
						r.b0     = CH_SP;
						r.pend   = 1'b0;
						r.lwn    = 1'b0;
					end
				end else if (oc1 < capx) begin
					r.n_emit = 2'd1;
					r.lwn    = 1'b0;
				end
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/html_entity_decode_space_collapse.sv @@
// ----------------------------------------------------------------------------
// html_entity_decode_space_collapse: HTML entity decoder with space collapse
// decodes numeric and named entities, replays failed lookahead and
// normalises whitespace through one shared per-byte sequencer
// ----------------------------------------------------------------------------
// sequencing: one byte through the sequencer per cycle while the output stage
//   accepts, with the second byte of a space pair and the flush handled as
//   separate steps; one item at a time, a new item is taken only in idle
// reset: arst_n clears control and normaliser state, capacity returns to 4096
// ----------------------------------------------------------------------------
module html_entity_decode_space_collapse (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import hed_pkg::*;

	state_t state_q, state_d;
	logic [15:0] cap_q;
	logic [7:0]  buf_q [BUF_DEPTH];
	logic [PTR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] hc_q, hc_d, tot_q, tot_d;
	logic stop_q, stop_d, fin_q, fin_d;
	logic [15:0] oc_q, oc_d;
	logic seen_q, seen_d, pend_q, pend_d, lwn_q, lwn_d;
	logic num_q, num_d, hex_q, hex_d, bad_q, bad_d;
	logic [8:0] val_q, val_d;
	logic [NUM_ENT-1:0] mask_q, mask_d;
	logic sec_v_q, sec_v_d;
	logic [7:0] sec_b_q, sec_b_d;
	logic hold_v_q;
	logic [7:0] hold_b_q;
	logic ov_q;
	logic [7:0] ob_q;
	logic olast_q;

	logic out_free, emit_ok, adv;
	logic emit_v, flush_last;
	logic [7:0] emit_b;
	logic pc_go;
	logic [7:0] pc_ch;
	pc_t pcr;
	logic wr_en;
	logic [PTR_W-1:0] rd_addr, wr_addr;
	logic [7:0] rd_byte;
	logic dec_ok;
	logic [7:0] dec_ch;
	logic [NUM_ENT-1:0] mask_upd;
	logic name_hit;
	logic [7:0] name_ch;
	logic [3:0] dig;
	logic dig_v;
	logic [12:0] acc;
	logic [8:0] val_upd;
	logic hex_upd, bad_upd, num_upd;

	// output side handshake
	assign out_free  = !ov_q || out_ready;
	assign emit_ok   = !hold_v_q || out_free;
	assign adv       = emit_ok && !sec_v_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign last      = olast_q;

	// lookahead buffer read
	assign rd_addr = (state_q == ST_PROC) ? head_q + PTR_W'(hc_q) : head_q;
	assign rd_byte = buf_q[rd_addr];
	assign wr_addr = head_q + PTR_W'(tot_q);

	// entity decoder: digit and name match for the byte at held position hc
	always_comb begin
		dig   = 4'd0;
		dig_v = 1'b0;
		if (rd_byte >= 8'h30 && rd_byte <= 8'h39) begin
			dig   = 4'(rd_byte - 8'h30);
			dig_v = 1'b1;
		end else if (hex_q && rd_byte >= 8'h61 && rd_byte <= 8'h66) begin
			dig   = 4'(rd_byte - 8'h57);
			dig_v = 1'b1;
		end else if (hex_q && rd_byte >= 8'h41 && rd_byte <= 8'h46) begin
			dig   = 4'(rd_byte - 8'h37);
			dig_v = 1'b1;
		end
		acc = hex_q ? {val_q, 4'b0000} : ({1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0});
		acc = acc + {9'd0, dig};
		val_upd = (acc > 13'(SAT_CODE)) ? SAT_CODE : acc[8:0];
		num_upd = num_q;
		hex_upd = hex_q;
		bad_upd = bad_q;
		if (hc_q == CNT_W'(1)) begin
			num_upd = (rd_byte == CH_HASH);
		end else if (hc_q == CNT_W'(2) && (rd_byte == 8'h78 || rd_byte == 8'h58)) begin
			hex_upd = 1'b1;
		end else if (!dig_v) begin
			bad_upd = 1'b1;
		end
		for (int k = 0; k < NUM_ENT; k++) begin
			mask_upd[k] = mask_q[k] && (ent_chr(k, hc_q - CNT_W'(1)) == to_lower(rd_byte));
		end
	end

	// entity decoder: result at the closing semicolon
	always_comb begin
		name_hit = 1'b0;
		name_ch  = CH_NUL;
		for (int k = 0; k < NUM_ENT; k++) begin
			if (mask_q[k] && CNT_W'(ENT_LEN[k]) == hc_q - CNT_W'(1)) begin
				name_hit = 1'b1;
				name_ch  = name_ch | ENT_CH[k];
			end
		end
		if (num_q) begin
			if (val_q == NBSP_CODE) dec_ch = CH_SP;
			else if (val_q == 9'd0 || val_q[8]) dec_ch = CH_QM;
			else dec_ch = val_q[7:0];
		end else begin
			dec_ch = name_ch;
		end
		dec_ok = (hc_q >= CNT_W'(2)) && (num_q ? !bad_q : name_hit);
	end

	// sequencer next state and normaliser
	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		hc_d    = hc_q;
		tot_d   = tot_q;
		stop_d  = stop_q;
		fin_d   = fin_q;
		oc_d    = oc_q;
		seen_d  = seen_q;
		pend_d  = pend_q;
		lwn_d   = lwn_q;
		num_d   = num_q;
		hex_d   = hex_q;
		bad_d   = bad_q;
		val_d   = val_q;
		mask_d  = mask_q;
		sec_v_d = sec_v_q;
		sec_b_d = sec_b_q;
		emit_v  = 1'b0;
		emit_b  = sec_b_q;
		flush_last = 1'b0;
		pc_go   = 1'b0;
		pc_ch   = rd_byte;
		wr_en   = 1'b0;

		if (sec_v_q) begin
			// second byte of a space plus character pair
			if (emit_ok) begin
				emit_v  = 1'b1;
				sec_v_d = 1'b0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (op)
							OP_TEXT: begin
								if (stop_q) begin
									state_d = ST_FLUSH;
								end else if (in_byte == CH_NUL) begin
									stop_d  = 1'b1;
									state_d = ST_DRAIN;
								end else begin
									wr_en   = 1'b1;
									tot_d   = tot_q + CNT_W'(1);
									state_d = ST_PROC;
								end
							end
							OP_END: begin
								stop_d  = 1'b0;
								state_d = ST_DRAIN;
							end
							OP_FINISH: begin
								fin_d   = 1'b1;
								state_d = ST_DRAIN;
							end
							default: state_d = ST_FLUSH;
						endcase
					end
				end
				ST_PROC: begin
					if (adv) begin
						if (hc_q == tot_q) begin
							state_d = ST_FLUSH;
						end else if (hc_q == CNT_W'(0)) begin
							if (rd_byte == CH_AMP) begin
								hc_d   = CNT_W'(1);
								num_d  = 1'b0;
								hex_d  = 1'b0;
								bad_d  = 1'b0;
								val_d  = 9'd0;
								mask_d = '1;
							end else begin
								pc_go  = 1'b1;
								head_d = head_q + PTR_W'(1);
								tot_d  = tot_q - CNT_W'(1);
							end
						end else if (rd_byte == CH_SEMI && dec_ok) begin
							// entity complete: consume it and pass the decoded byte on
							pc_go  = 1'b1;
							pc_ch  = dec_ch;
							head_d = head_q + PTR_W'(hc_q) + PTR_W'(1);
							tot_d  = tot_q - hc_q - CNT_W'(1);
							hc_d   = CNT_W'(0);
						end else if (rd_byte != CH_SEMI &&
								({1'b0, hc_q} + 5'd1) < 5'(ENTITY_WINDOW)) begin
							hc_d   = hc_q + CNT_W'(1);
							num_d  = num_upd;
							hex_d  = hex_upd;
							bad_d  = bad_upd;
							if (hc_q >= CNT_W'(2) && !(hex_upd && !hex_q))
								val_d = val_upd;
							mask_d = mask_upd;
						end else begin
							// failed entity: literal ampersand, held bytes replay
							pc_go  = 1'b1;
							pc_ch  = CH_AMP;
							head_d = head_q + PTR_W'(1);
							tot_d  = tot_q - CNT_W'(1);
							hc_d   = CNT_W'(0);
						end
					end
				end
				ST_DRAIN: begin
					if (adv) begin
						if (hc_q == CNT_W'(0)) begin
							tot_d   = CNT_W'(0);
							state_d = fin_q ? ST_FINSP : ST_FLUSH;
						end else begin
							pc_go  = 1'b1;
							head_d = head_q + PTR_W'(1);
							hc_d   = hc_q - CNT_W'(1);
							tot_d  = tot_q - CNT_W'(1);
						end
					end
				end
				ST_FINSP: begin
					if (adv) begin
						if (pend_q && cap_q != 16'd0 && ({1'b0, oc_q} + 17'd1) < {1'b0, cap_q}) begin
							emit_v = 1'b1;
							emit_b = CH_SP;
						end
						oc_d    = 16'd0;
						stop_d  = 1'b0;
						fin_d   = 1'b0;
						seen_d  = 1'b0;
						pend_d  = 1'b0;
						lwn_d   = 1'b0;
						hc_d    = CNT_W'(0);
						tot_d   = CNT_W'(0);
						state_d = ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!hold_v_q) begin
						state_d = ST_IDLE;
					end else if (out_free) begin
						flush_last = 1'b1;
						state_d    = ST_IDLE;
					end
				end
				default: state_d = ST_IDLE;
			endcase
		end

		// shared normaliser step
		pcr = put_char(pc_ch, cap_q, oc_q, pend_q, seen_q, lwn_q);
		if (pc_go) begin
			pend_d = pcr.pend;
			seen_d = pcr.seen;
			lwn_d  = pcr.lwn;
			oc_d   = oc_q + 16'(pcr.n_emit);
			if (pcr.n_emit != 2'd0) begin
				emit_v = 1'b1;
				emit_b = pcr.b0;
			end
			if (pcr.n_emit == 2'd2) begin
				sec_v_d = 1'b1;
				sec_b_d = pcr.b1;
			end
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= 16'd4096;
			head_q  <= '0;
			hc_q    <= '0;
			tot_q   <= '0;
			stop_q  <= 1'b0;
			fin_q   <= 1'b0;
			oc_q    <= '0;
			seen_q  <= 1'b0;
			pend_q  <= 1'b0;
			lwn_q   <= 1'b0;
			sec_v_q <= 1'b0;
			hold_v_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cap_q <= cfg_wdata;
			head_q  <= head_d;
			hc_q    <= hc_d;
			tot_q   <= tot_d;
			stop_q  <= stop_d;
			fin_q   <= fin_d;
			oc_q    <= oc_d;
			seen_q  <= seen_d;
			pend_q  <= pend_d;
			lwn_q   <= lwn_d;
			sec_v_q <= sec_v_d;
			// output register: hold stage moves on when its successor is known
			if (emit_v) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) ov_q <= 1'b1;
				else if (out_ready) ov_q <= 1'b0;
			end else if (flush_last) begin
				hold_v_q <= 1'b0;
				ov_q     <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		num_q   <= num_d;
		hex_q   <= hex_d;
		bad_q   <= bad_d;
		val_q   <= val_d;
		mask_q  <= mask_d;
		sec_b_q <= sec_b_d;
		if (wr_en) buf_q[wr_addr] <= in_byte;
		if (emit_v) begin
			hold_b_q <= emit_b;
			if (hold_v_q) begin
				ob_q    <= hold_b_q;
				olast_q <= 1'b0;
			end
		end else if (flush_last) begin
			ob_q    <= hold_b_q;
			olast_q <= 1'b1;
		end
	end

	// checks
	a_tot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tot_q <= CNT_W'(ENTITY_WINDOW))
		else $error("lookahead buffer overfilled");

	a_held_in_queue: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q <= tot_q)
		else $error("held count beyond buffered bytes");

	a_sec_has_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sec_v_q |-> hold_v_q)
		else $error("second byte pending without a held byte");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!hold_v_q && !sec_v_q && hc_q == tot_q))
		else $error("idle with result bytes or queued bytes outstanding");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_v |-> emit_ok)
		else $error("emit while the output stage is blocked");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the html entity decoder with space collapse
// drives text, end-of-chunk, finish and unused-op items under random back-pressure,
// predicts every output byte with a behavioural decoder and normaliser,
// and compares each output transfer with the oldest predicted byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import hed_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WD_LIMIT = 20000;
	localparam int SETTLE = 40;
	localparam int RES_MAX = 24;

	typedef struct {
		logic [1:0] op;
		logic [7:0] b;
	} text_item_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
	} out_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_TEXT;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;

	html_entity_decode_space_collapse dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .in_byte(in_byte),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte), .last(last),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	text_item_t pending_items[$];
	out_beat_t  decoded_bytes[$];
	int         n_queued = 0;
	int         n_taken = 0;
	int         errors = 0;
	int         snd_idle = 0;
	int         rcv_idle = 0;
	int         wd_count = 0;
	bit         took = 1'b0;

	// behavioural decoder state
	logic [15:0] buf_cap = 16'd4096;
	logic [7:0]  held [ENTITY_WINDOW];
	int          held_n = 0;
	bit          stopped = 0;
	logic [15:0] out_cnt = 16'd0;
	bit          sp_seen = 0;
	bit          sp_pend = 0;
	bit          after_nl = 0;
	int          step_n = 0;

	string       ent_names [28] = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg",
		"deg", "plusmn", "laquo", "raquo", "mdash", "ndash", "hellip", "ldquo", "rdquo",
		"lsquo", "rsquo", "trade", "times", "divide", "middot", "bull", "euro", "pound",
		"yen", "sect"};
	logic [7:0]  ent_chars [28] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20, 8'hA9, 8'hAE,
		8'hB0, 8'hB1, 8'hAB, 8'hBB, 8'h2D, 8'h2D, 8'h2E, 8'h27, 8'h27, 8'h27, 8'h27,
		8'h2A, 8'h78, 8'h2F, 8'h2E, 8'h2A, 8'h45, 8'hA3, 8'hA5, 8'hA7};

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		out_beat_t e;
		if (step_n < RES_MAX) begin
			e.b = b;
			e.last = 1'b0;
			decoded_bytes.push_back(e);
			step_n++;
		end
		out_cnt = out_cnt + 16'd1;
	endtask

	// whitespace normaliser
	task automatic normalise(input logic [7:0] c_in);
		logic [7:0] c;
		int oc;
		int cp;
		c = c_in;
		oc = int'(out_cnt);
		cp = int'(buf_cap);
		if (cp == 0) return;
		if (c == CH_CR || c == CH_TAB || c == CH_FF) c = CH_SP;
		if (c == CH_NL) begin
			sp_pend = 0;
			sp_seen = 1;
			if (oc > 0 && after_nl) return;
			if (oc + 1 < cp) begin
				push_byte(CH_NL);
				after_nl = 1;
			end
			return;
		end
		if (c == CH_SP) begin
			if ((oc == 0 && !sp_pend) || sp_seen || (!sp_pend && after_nl)) return;
			sp_seen = 1;
			if (!sp_pend && oc + 1 < cp) sp_pend = 1;
			return;
		end
		sp_seen = 0;
		if (sp_pend) begin
			if (oc + 2 < cp) begin
				push_byte(CH_SP);
				push_byte(c);
				sp_pend = 0;
				after_nl = 0;
			end
		end else if (oc + 1 < cp) begin
			push_byte(c);
			after_nl = 0;
		end
	endtask

	function automatic logic [7:0] lc(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
	endfunction

	// held[0] is the ampersand, held[held_n-1] the semicolon
	function automatic bit entity_value(output logic [7:0] d);
		int semi;
		int value;
		int base;
		int p;
		int dg;
		int len;
		int j;
		logic [7:0] c;
		semi = held_n - 1;
		d = 8'h00;
		if (held_n < 3) return 0;
		if (held[1] == CH_HASH) begin
			value = 0;
			base = 10;
			p = 2;
			if (p < semi && (held[p] == "x" || held[p] == "X")) begin
				base = 16;
				p++;
			end
			for (; p < semi; p++) begin
				c = held[p];
				if (c >= "0" && c <= "9") dg = int'(c) - int'("0");
				else if (base == 16 && c >= "a" && c <= "f") dg = 10 + int'(c) - int'("a");
				else if (base == 16 && c >= "A" && c <= "F") dg = 10 + int'(c) - int'("A");
				else return 0;
				value = value * base + dg;
				if (value > 256) value = 256;
			end
			if (value == 160) d = CH_SP;
			else if (value == 0 || value > 255) d = CH_QM;
			else d = value[7:0];
			return 1;
		end
		len = semi - 1;
		foreach (ent_names[k]) begin
			for (j = 0; j < len && j < ent_names[k].len(); j++)
				if (lc(held[1 + j]) != ent_names[k][j]) break;
			if (j == len && j == ent_names[k].len()) begin
				d = ent_chars[k];
				return 1;
			end
		end
		return 0;
	endfunction

	// entity lookahead with replay of failed bytes
	task automatic take_text(input logic [7:0] first);
		logic [7:0] q[$];
		logic [7:0] b;
		logic [7:0] d;
		int rn;
		q.push_back(first);
		while (q.size() > 0) begin
			b = q.pop_front();
			if (held_n == 0) begin
				if (b == CH_AMP) begin
					held[0] = b;
					held_n = 1;
				end else normalise(b);
				continue;
			end
			held[held_n] = b;
			held_n++;
			if (b == CH_SEMI) begin
				if (entity_value(d)) begin
					held_n = 0;
					normalise(d);
					continue;
				end
			end else if (held_n < ENTITY_WINDOW) continue;
			rn = held_n - 1;
			if (rn + q.size() > 2 * ENTITY_WINDOW + 2) rn = 2 * ENTITY_WINDOW + 2 - q.size();
			for (int k = rn - 1; k >= 0; k--) q.push_front(held[1 + k]);
			held_n = 0;
			normalise(CH_AMP);
		end
	endtask

	task automatic flush_held();
		int n;
		n = held_n;
		held_n = 0;
		for (int k = 0; k < n && k < ENTITY_WINDOW; k++) normalise(held[k]);
	endtask

	task automatic clear_decoder();
		held_n = 0;
		stopped = 0;
		out_cnt = 16'd0;
		sp_seen = 0;
		sp_pend = 0;
		after_nl = 0;
	endtask

	task automatic predict_item(input logic [1:0] o, input logic [7:0] b);
		step_n = 0;
		if (o == OP_TEXT) begin
			if (!stopped) begin
				if (b == CH_NUL) begin
					flush_held();
					stopped = 1;
				end else take_text(b);
			end
		end else if (o == OP_END) begin
			flush_held();
			stopped = 0;
		end else if (o == OP_FINISH) begin
			flush_held();
			if (sp_pend && buf_cap != 16'd0 && int'(out_cnt) + 1 < int'(buf_cap))
				push_byte(CH_SP);
			clear_decoder();
		end
		if (step_n > 0) decoded_bytes[decoded_bytes.size() - 1].last = 1'b1;
	endtask

	// input transfers feed the predictor, output transfers are checked
	always @(posedge clk) begin
		took = in_valid && in_ready;
		if (took) begin
			predict_item(op, in_byte);
			n_taken++;
		end
		if (out_valid && out_ready) begin
			if (decoded_bytes.size() == 0) report($sformatf("unexpected byte %02h", out_byte));
			else begin
				if (out_byte !== decoded_bytes[0].b)
					report($sformatf("byte %02h, want %02h", out_byte, decoded_bytes[0].b));
				if (last !== decoded_bytes[0].last)
					report($sformatf("last %b, want %b", last, decoded_bytes[0].last));
				void'(decoded_bytes.pop_front());
			end
		end
		if (took || (out_valid && out_ready)) wd_count = 0;
		else wd_count++;
		if (wd_count >= WD_LIMIT) begin
			$display("html_entity_decode_space_collapse verification failed");
			$finish;
		end
	end

	// driver for the input channel
	always @(negedge clk) begin
		text_item_t it;
		if (!arst_n) in_valid <= 1'b0;
		else if (!in_valid || took) begin
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
				it = pending_items.pop_front();
				in_valid <= 1'b1;
				op <= it.op;
				in_byte <= it.b;
			end else in_valid <= 1'b0;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(0, 99) >= rcv_idle);
	end

	task automatic add_item(input logic [1:0] o, input logic [7:0] b);
		text_item_t it;
		it.op = o;
		it.b = b;
		pending_items.push_back(it);
		n_queued++;
	endtask

	task automatic add_text(input string s);
		for (int k = 0; k < s.len(); k++) add_item(OP_TEXT, s[k]);
	endtask

	function automatic logic [7:0] mixed_case(input logic [7:0] c);
		return (c >= "a" && c <= "z" && $urandom_range(0, 1)) ? c - 8'h20 : c;
	endfunction

	task automatic add_random(input int n);
		int stop_at;
		int sel;
		int cnt;
		string nm;
		string hex_digits;
		logic [7:0] ws [5] = '{CH_SP, CH_TAB, CH_CR, CH_FF, CH_NL};
		hex_digits = "0123456789abcdef";
		stop_at = n_queued + n;
		while (n_queued < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				// well-formed entity, now and then broken
				add_item(OP_TEXT, CH_AMP);
				cnt = $urandom_range(0, 2);
				if (cnt == 0) begin
					nm = ent_names[$urandom_range(0, 27)];
					for (int k = 0; k < nm.len(); k++) add_item(OP_TEXT, mixed_case(nm[k]));
				end else begin
					add_item(OP_TEXT, CH_HASH);
					if (cnt == 2) add_item(OP_TEXT, $urandom_range(0, 1) ? "x" : "X");
					repeat ($urandom_range(0, 4)) begin
						if (cnt == 2)
							add_item(OP_TEXT, mixed_case(hex_digits[$urandom_range(0, 15)]));
						else add_item(OP_TEXT, 8'("0" + $urandom_range(0, 9)));
					end
				end
				if ($urandom_range(0, 9) == 0) add_item(OP_TEXT, 8'("a" + $urandom_range(0, 25)));
				add_item(OP_TEXT, CH_SEMI);
			end else if (sel < 55) begin
				repeat ($urandom_range(1, 6))
					add_item(OP_TEXT, mixed_case(8'("a" + $urandom_range(0, 25))));
			end else if (sel < 75) begin
				repeat ($urandom_range(1, 4)) add_item(OP_TEXT, ws[$urandom_range(0, 4)]);
			end else if (sel < 85) begin
				add_item(OP_TEXT, 8'($urandom_range(0, 255)));
			end else if (sel < 90) begin
				// ampersand and a run of letters, at times long enough to overrun the window
				add_item(OP_TEXT, CH_AMP);
				repeat ($urandom_range(1, 14)) add_item(OP_TEXT, 8'("a" + $urandom_range(0, 25)));
			end else if (sel < 95) add_item(OP_END, 8'($urandom_range(0, 255)));
			else if (sel < 98) add_item(OP_FINISH, 8'($urandom_range(0, 255)));
			else add_item(OP_UNUSED, 8'($urandom_range(0, 255)));
		end
	endtask

	// wait for every transfer and byte, let the block settle, then write capacity
	task automatic set_capacity(input logic [15:0] v);
		do @(negedge clk); while (n_taken != n_queued || decoded_bytes.size() != 0);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		buf_cap = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus sequence
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		snd_idle = 37;
		rcv_idle = 73;
		add_text("&Amp;&#160;&#;&#x0;");
		add_text(" \r\t\f\n\nx ");
		add_item(OP_TEXT, 8'hFF);
		add_item(OP_TEXT, CH_NUL);
		add_item(OP_TEXT, "q");
		add_item(OP_UNUSED, 8'hFF);
		add_item(OP_END, 8'h00);
		add_item(OP_FINISH, 8'h00);
		set_capacity(16'd65535);
		add_random(120);
		set_capacity(16'd1);
		snd_idle = 73;
		rcv_idle = 37;
		add_random(40);
		set_capacity(16'd12);
		add_random(100);
		set_capacity(16'd0);
		snd_idle = 0;
		rcv_idle = 0;
		add_random(30);
		set_capacity(16'd30);
		add_random(100);
		set_capacity(16'd4096);
		add_random(90);
		do @(negedge clk); while (n_taken != n_queued || decoded_bytes.size() != 0);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0 && decoded_bytes.size() == 0)
			$display("html_entity_decode_space_collapse verification clean");
		else
			$display("html_entity_decode_space_collapse verification failed");
		$finish;
	end

endmodule
